// File: rtl/tps_pkg.sv
// ----------------------------------------------------------------------------
// tps_pkg
// Shared codes for the triangle plane split unit: register indexes, edge
// codes and result source codes.
// ----------------------------------------------------------------------------
package tps_pkg;

  localparam int CFG_ADDR_W = 3;
  localparam int SRC_W      = 3;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    CFG_NORMAL_X = 3'd0,
    CFG_NORMAL_Y = 3'd1,
    CFG_NORMAL_Z = 3'd2,
    CFG_POINT_X  = 3'd3,
    CFG_POINT_Y  = 3'd4,
    CFG_POINT_Z  = 3'd5
  } cfg_idx_t;

  // Triangle edges
  localparam logic [1:0] EDGE_AB = 2'd0;
  localparam logic [1:0] EDGE_BC = 2'd1;
  localparam logic [1:0] EDGE_CA = 2'd2;

  // Result source codes
  localparam logic [SRC_W-1:0] SRC_A  = 3'd0;
  localparam logic [SRC_W-1:0] SRC_B  = 3'd1;
  localparam logic [SRC_W-1:0] SRC_C  = 3'd2;
  localparam logic [SRC_W-1:0] SRC_AB = 3'd3;

endpackage

// File: rtl/tps_div_lane.sv
// ----------------------------------------------------------------------------
// tps_div_lane
// Pipelined long division floor(dvd * s0 / den), one dividend bit per stage.
// Each stage doubles the remainder, adds s0 when the bit is set and takes
// out zero, one or two divisors (s0 <= den keeps the digit below three).
// ----------------------------------------------------------------------------
module tps_div_lane #(
  parameter int CW = 16,
  parameter int DW = 35
) (
  input  logic          clk,
  input  logic          en,
  input  logic [CW:0]   dvd_i,
  input  logic [DW-1:0] s0_i,
  input  logic [DW-1:0] den_i,
  output logic [CW:0]   q_o
);

  localparam int NST = CW + 1;
  localparam int RW  = DW + 2;

  logic [DW-1:0] r_r   [NST];
  logic [CW:0]   q_r   [NST];
  logic [CW:0]   dv_r  [NST];
  logic [DW-1:0] s0_r  [NST];
  logic [DW-1:0] den_r [NST];

  genvar k;
  for (k = 0; k < NST; k++) begin : g_st
    logic [DW-1:0] r_in, s0_in, den_in, r_nxt;
    logic [CW:0]   q_in, dv_in;
    logic [RW-1:0] t, t1, t2, den1, den2;
    logic [1:0]    dig;
    logic [CW+1:0] q_w;

    if (k == 0) begin : g_first
      assign r_in   = '0;
      assign q_in   = '0;
      assign dv_in  = dvd_i;
      assign s0_in  = s0_i;
      assign den_in = den_i;
    end else begin : g_next
      assign r_in   = r_r[k-1];
      assign q_in   = q_r[k-1];
      assign dv_in  = dv_r[k-1];
      assign s0_in  = s0_r[k-1];
      assign den_in = den_r[k-1];
    end

    // Shift in one bit of the dividend and reduce
    always_comb begin
      t    = {1'b0, r_in, 1'b0} + (dv_in[CW-k] ? RW'(s0_in) : '0);
      den1 = RW'(den_in);
      den2 = {1'b0, den_in, 1'b0};
      t1   = t - den1;
      t2   = t - den2;
      if (t >= den2) begin
        dig = 2'd2;
        r_nxt = t2[DW-1:0];
      end else if (t >= den1) begin
        dig = 2'd1;
        r_nxt = t1[DW-1:0];
      end else begin
        dig = 2'd0;
        r_nxt = t[DW-1:0];
      end
      q_w = {q_in, 1'b0} + (CW+2)'(dig);
    end

    // Advance the stage
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]   <= r_nxt;
        q_r[k]   <= q_w[CW:0];
        dv_r[k]  <= dv_in;
        s0_r[k]  <= s0_in;
        den_r[k] <= den_in;
      end
    end
  end

  assign q_o = q_r[NST-1];

endmodule

// File: rtl/triangle_plane_split_unit.sv
// ----------------------------------------------------------------------------
// triangle_plane_split_unit
// Splits a triangle by a configured plane and streams out the tagged vertices.
// ----------------------------------------------------------------------------
// One triangle goes in per item; it yields three to five result items, one per
// cycle while out_tready is high: the vertices a, b, c marked above/below (both
// when on the plane), then the intersection points of the edges that cross the
// plane. The result port sets the sustained rate: a new triangle is taken only
// when the result buffer is empty or its last result is accepted. A triangle
// passes four stages of distance math and operand setup, then one long-division
// stage per quotient bit (COORD_WIDTH + 1), then the result buffer. Write the
// plane registers only while no triangle is in flight.
module triangle_plane_split_unit import tps_pkg::*; #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (lowest bits first)
  input  logic [((9*COORD_WIDTH+7)/8)*8-1:0]      in_tdata,
  input  logic                                    in_tvalid,
  output logic                                    in_tready,
  // out_x, out_y, out_z (lowest bits first)
  output logic [((3*COORD_WIDTH+7)/8)*8-1:0]      out_tdata,
  // to_above, to_below, source[2:0] (lowest bits first)
  output logic [4:0]                              out_tuser,
  output logic                                    out_tlast,
  output logic                                    out_tvalid,
  input  logic                                    out_tready,
  input  logic                                    cfg_wr_en,
  input  logic [CFG_ADDR_W-1:0]                   cfg_addr,
  input  logic [COORD_WIDTH-1:0]                  cfg_wdata
);

  localparam int CW    = COORD_WIDTH;
  localparam int OUT_W = ((3*CW+7)/8)*8;
  localparam int PW    = 2*CW;
  localparam int SW    = 2*CW + 3;
  localparam int NST   = CW + 1;

  logic en;

  // --------------------------------------------------------------------------
  // Plane registers
  logic signed [CW-1:0] nrm_r [3];
  logic signed [CW-1:0] pnt_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nrm_r[0] <= '0;
      nrm_r[1] <= '0;
      nrm_r[2] <= {{(CW-1){1'b0}}, 1'b1} << FRAC_BITS;
      pnt_r[0] <= '0;
      pnt_r[1] <= '0;
      pnt_r[2] <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_NORMAL_X: nrm_r[0] <= cfg_wdata;
        CFG_NORMAL_Y: nrm_r[1] <= cfg_wdata;
        CFG_NORMAL_Z: nrm_r[2] <= cfg_wdata;
        CFG_POINT_X:  pnt_r[0] <= cfg_wdata;
        CFG_POINT_Y:  pnt_r[1] <= cfg_wdata;
        CFG_POINT_Z:  pnt_r[2] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: products n.v and n.p
  logic signed [CW-1:0] vin [9];
  logic                 val1_r;
  logic signed [CW-1:0] v1_r  [9];
  logic signed [PW-1:0] pr1_r [9];
  logic signed [PW-1:0] np1_r [3];

  always_comb begin
    for (int i = 0; i < 9; i++) vin[i] = $signed(in_tdata[i*CW +: CW]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) val1_r <= 1'b0;
    else if (en) val1_r <= in_tvalid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 9; i++) begin
        v1_r[i]  <= vin[i];
        pr1_r[i] <= vin[i] * nrm_r[i%3];
      end
      for (int j = 0; j < 3; j++) np1_r[j] <= nrm_r[j] * pnt_r[j];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: signed distances
  logic                 val2_r;
  logic signed [CW-1:0] v2_r [9];
  logic signed [SW-1:0] s2_r [3];

  always_ff @(posedge clk) begin
    if (!rst_n) val2_r <= 1'b0;
    else if (en) val2_r <= val1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v2_r <= v1_r;
      for (int i = 0; i < 3; i++) begin
        s2_r[i] <= SW'(pr1_r[3*i]) + SW'(pr1_r[3*i+1]) + SW'(pr1_r[3*i+2])
                 - (SW'(np1_r[0]) + SW'(np1_r[1]) + SW'(np1_r[2]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: classify vertices, pick up to two crossing edges
  logic [2:0] pos, neg, xing;
  logic [1:0] eg_nxt [2];
  logic [1:0] sv_nxt;
  logic signed [CW-1:0] p0_nxt [2][3];
  logic signed [CW-1:0] p1_nxt [2][3];
  logic signed [SW-1:0] sa_nxt [2];
  logic signed [SW-1:0] sb_nxt [2];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      neg[i] = s2_r[i][SW-1];
      pos[i] = !s2_r[i][SW-1] && (s2_r[i] != '0);
    end
    for (int i = 0; i < 3; i++) begin
      xing[i] = (pos[i] && neg[(i+1)%3]) || (neg[i] && pos[(i+1)%3]);
    end
    eg_nxt[0] = xing[0] ? EDGE_AB : (xing[1] ? EDGE_BC : EDGE_CA);
    eg_nxt[1] = (xing[0] && xing[1]) ? EDGE_BC : EDGE_CA;
    sv_nxt[0] = |xing;
    sv_nxt[1] = (xing[0] & xing[1]) | (xing[0] & xing[2]) | (xing[1] & xing[2]);
    for (int k = 0; k < 2; k++) begin
      unique case (eg_nxt[k])
        EDGE_BC: begin
          for (int j = 0; j < 3; j++) begin
            p0_nxt[k][j] = v2_r[3+j];
            p1_nxt[k][j] = v2_r[6+j];
          end
          sa_nxt[k] = s2_r[1];
          sb_nxt[k] = s2_r[2];
        end
        EDGE_CA: begin
          for (int j = 0; j < 3; j++) begin
            p0_nxt[k][j] = v2_r[6+j];
            p1_nxt[k][j] = v2_r[j];
          end
          sa_nxt[k] = s2_r[2];
          sb_nxt[k] = s2_r[0];
        end
        default: begin
          for (int j = 0; j < 3; j++) begin
            p0_nxt[k][j] = v2_r[j];
            p1_nxt[k][j] = v2_r[3+j];
          end
          sa_nxt[k] = s2_r[0];
          sb_nxt[k] = s2_r[1];
        end
      endcase
    end
  end

  logic                 val3_r;
  logic signed [CW-1:0] v3_r  [9];
  logic [5:0]           ab3_r;
  logic [1:0]           sv3_r;
  logic [1:0]           eg3_r [2];
  logic signed [CW-1:0] p03_r [2][3];
  logic signed [CW-1:0] p13_r [2][3];
  logic signed [SW-1:0] sa3_r [2];
  logic signed [SW-1:0] sb3_r [2];

  always_ff @(posedge clk) begin
    if (!rst_n) val3_r <= 1'b0;
    else if (en) val3_r <= val2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v3_r  <= v2_r;
      ab3_r <= {~pos, ~neg};
      sv3_r <= sv_nxt;
      eg3_r <= eg_nxt;
      p03_r <= p0_nxt;
      p13_r <= p1_nxt;
      sa3_r <= sa_nxt;
      sb3_r <= sb_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: edge deltas, magnitudes and divisor
  logic                 val4_r;
  logic signed [CW-1:0] v4_r    [9];
  logic [5:0]           ab4_r;
  logic [1:0]           sv4_r;
  logic [1:0]           eg4_r   [2];
  logic signed [CW-1:0] base4_r [2][3];
  logic                 neg4_r  [2][3];
  logic [CW:0]          dab4_r  [2][3];
  logic [SW-1:0]        s0a4_r  [2];
  logic [SW-1:0]        den4_r  [2];

  logic signed [CW:0] dlt [2][3];
  logic [SW-1:0]      sa_abs [2];
  logic [SW-1:0]      sb_abs [2];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 3; j++) begin
        dlt[k][j] = (CW+1)'(p13_r[k][j]) - (CW+1)'(p03_r[k][j]);
      end
      sa_abs[k] = sa3_r[k][SW-1] ? SW'(-sa3_r[k]) : SW'(sa3_r[k]);
      sb_abs[k] = sb3_r[k][SW-1] ? SW'(-sb3_r[k]) : SW'(sb3_r[k]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) val4_r <= 1'b0;
    else if (en) val4_r <= val3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      v4_r    <= v3_r;
      ab4_r   <= ab3_r;
      sv4_r   <= sv3_r;
      eg4_r   <= eg3_r;
      base4_r <= p03_r;
      for (int k = 0; k < 2; k++) begin
        for (int j = 0; j < 3; j++) begin
          neg4_r[k][j] <= dlt[k][j][CW];
          dab4_r[k][j] <= dlt[k][j][CW] ? (CW+1)'(-dlt[k][j]) : (CW+1)'(dlt[k][j]);
        end
        s0a4_r[k] <= sa_abs[k];
        den4_r[k] <= sa_abs[k] + sb_abs[k];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Division lanes: two crossing slots by three coordinates
  logic [CW:0] quo [2][3];

  genvar gk, gj;
  for (gk = 0; gk < 2; gk++) begin : g_slot
    for (gj = 0; gj < 3; gj++) begin : g_crd
      tps_div_lane #(
        .CW (CW),
        .DW (SW)
      ) u_lane (
        .clk   (clk),
        .en    (en),
        .dvd_i (dab4_r[gk][gj]),
        .s0_i  (s0a4_r[gk]),
        .den_i (den4_r[gk]),
        .q_o   (quo[gk][gj])
      );
    end
  end

  // Carry the triangle alongside the lanes
  logic                 mv_r    [NST];
  logic signed [CW-1:0] mvt_r   [NST][9];
  logic [5:0]           mab_r   [NST];
  logic [1:0]           msv_r   [NST];
  logic [1:0]           meg_r   [NST][2];
  logic signed [CW-1:0] mbase_r [NST][2][3];
  logic                 mneg_r  [NST][2][3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) mv_r[k] <= 1'b0;
    end else if (en) begin
      mv_r[0] <= val4_r;
      for (int k = 1; k < NST; k++) mv_r[k] <= mv_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mvt_r[0]   <= v4_r;
      mab_r[0]   <= ab4_r;
      msv_r[0]   <= sv4_r;
      meg_r[0]   <= eg4_r;
      mbase_r[0] <= base4_r;
      mneg_r[0]  <= neg4_r;
      for (int k = 1; k < NST; k++) begin
        mvt_r[k]   <= mvt_r[k-1];
        mab_r[k]   <= mab_r[k-1];
        msv_r[k]   <= msv_r[k-1];
        meg_r[k]   <= meg_r[k-1];
        mbase_r[k] <= mbase_r[k-1];
        mneg_r[k]  <= mneg_r[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Intersection points: base plus signed quotient
  logic signed [CW+1:0] pt_w [2][3];
  logic [CW+1:0]        qx   [2][3];

  always_comb begin
    for (int k = 0; k < 2; k++) begin
      for (int j = 0; j < 3; j++) begin
        qx[k][j]   = {1'b0, quo[k][j]};
        pt_w[k][j] = (CW+2)'(mbase_r[NST-1][k][j])
                   + (mneg_r[NST-1][k][j] ? -$signed(qx[k][j]) : $signed(qx[k][j]));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result buffer: hold one triangle's results, send one per cycle while out_tready is high
  logic [3*CW-1:0] ex_r [5];
  logic            ea_r [5];
  logic            eb_r [5];
  logic [SRC_W-1:0] es_r [5];
  logic [2:0]      elast_r;
  logic [2:0]      idx_r;
  logic            emv_r;

  assign out_tvalid = emv_r;
  assign out_tdata  = OUT_W'(ex_r[idx_r]);
  assign out_tuser  = {es_r[idx_r], eb_r[idx_r], ea_r[idx_r]};
  assign out_tlast  = (idx_r == elast_r);
  assign en         = !emv_r || (out_tready && out_tlast);
  assign in_tready  = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      emv_r <= 1'b0;
      idx_r <= '0;
    end else if (en) begin
      emv_r <= mv_r[NST-1];
      idx_r <= '0;
    end else if (out_tready) begin
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (en && mv_r[NST-1]) begin
      for (int i = 0; i < 3; i++) begin
        ex_r[i] <= {mvt_r[NST-1][3*i+2], mvt_r[NST-1][3*i+1], mvt_r[NST-1][3*i]};
        ea_r[i] <= mab_r[NST-1][i];
        eb_r[i] <= mab_r[NST-1][3+i];
      end
      es_r[0] <= SRC_A;
      es_r[1] <= SRC_B;
      es_r[2] <= SRC_C;
      for (int k = 0; k < 2; k++) begin
        ex_r[3+k] <= {pt_w[k][2][CW-1:0], pt_w[k][1][CW-1:0], pt_w[k][0][CW-1:0]};
        ea_r[3+k] <= 1'b1;
        eb_r[3+k] <= 1'b1;
        es_r[3+k] <= SRC_AB + {1'b0, meg_r[NST-1][k]};
      end
      elast_r <= msv_r[NST-1][1] ? 3'd4 : (msv_r[NST-1][0] ? 3'd3 : 3'd2);
    end
  end

endmodule

// File: dv/tb_triangle_plane_split_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_triangle_plane_split_unit
// Streams triangles through the split unit under several plane settings and
// checks every tagged vertex against a predictor kept in the testbench.
// ----------------------------------------------------------------------------

// Expected vertex with its tags
typedef struct packed {
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic signed [15:0] z;
  logic               above;
  logic               below;
  logic [2:0]         src;
  logic               last;
} split_vtx_t;

// Holds expected vertices in arrival order and checks results against them
class split_scoreboard;
  split_vtx_t pending[$];
  int         n_errors;
  logic signed [15:0] nrm[3];
  logic signed [15:0] pnt[3];

  function new();
    n_errors = 0;
    nrm[0] = 0; nrm[1] = 0; nrm[2] = 16'sd256;
    pnt[0] = 0; pnt[1] = 0; pnt[2] = 0;
  endfunction

  function void set_reg(int idx, logic [15:0] val);
    if (idx < 3) nrm[idx] = val;
    else if (idx < 6) pnt[idx-3] = val;
  endfunction

  // Predict the vertices and edge crossings of one accepted triangle
  function void note_triangle(logic [143:0] data);
    longint     v[3][3];
    longint     sd[3];
    longint     np, s0, s1, den;
    split_vtx_t r;
    int         e;
    np = 0;
    for (int j = 0; j < 3; j++) np += longint'(nrm[j]) * longint'(pnt[j]);
    for (int i = 0; i < 3; i++) begin
      sd[i] = -np;
      for (int j = 0; j < 3; j++) begin
        v[i][j] = longint'($signed(data[(i*3+j)*16 +: 16]));
        sd[i] += longint'(nrm[j]) * v[i][j];
      end
    end
    for (int i = 0; i < 3; i++) begin
      r.x = 16'(v[i][0]); r.y = 16'(v[i][1]); r.z = 16'(v[i][2]);
      r.above = sd[i] >= 0; r.below = sd[i] <= 0;
      r.src = 3'(i); r.last = 0;
      pending.insert(pending.size(), r);
    end
    for (int i = 0; i < 3; i++) begin
      e = (i + 1) % 3;
      s0 = sd[i]; s1 = sd[e];
      if ((s0 > 0 && s1 < 0) || (s0 < 0 && s1 > 0)) begin
        den = s0 - s1;
        r.x = 16'(v[i][0] + ((v[e][0] - v[i][0]) * s0) / den);
        r.y = 16'(v[i][1] + ((v[e][1] - v[i][1]) * s0) / den);
        r.z = 16'(v[i][2] + ((v[e][2] - v[i][2]) * s0) / den);
        r.above = 1; r.below = 1; r.src = 3'(3 + i); r.last = 0;
        pending.insert(pending.size(), r);
      end
    end
    pending[pending.size()-1].last = 1;
  endfunction

  task report(string what);
    $display("[%0t] mismatch: %s", $time, what);
    n_errors++;
  endtask

  // Compare one accepted result with the oldest expectation
  task check_vertex(logic [47:0] data, logic [4:0] user, logic tlast);
    split_vtx_t ex;
    if (pending.size() == 0) begin
      report($sformatf("unexpected vertex %h/%h", data, user));
      return;
    end
    ex = pending.pop_front();
    if (data[15:0] !== ex.x) report($sformatf("x %h exp %h", data[15:0], ex.x));
    if (data[31:16] !== ex.y) report($sformatf("y %h exp %h", data[31:16], ex.y));
    if (data[47:32] !== ex.z) report($sformatf("z %h exp %h", data[47:32], ex.z));
    if (user[0] !== ex.above) report($sformatf("above %b exp %b", user[0], ex.above));
    if (user[1] !== ex.below) report($sformatf("below %b exp %b", user[1], ex.below));
    if (user[4:2] !== ex.src) report($sformatf("source %0d exp %0d", user[4:2], ex.src));
    if (tlast !== ex.last) report($sformatf("last %b exp %b", tlast, ex.last));
  endtask
endclass

module tb_triangle_plane_split_unit import tps_pkg::*; ();

  localparam int LATENCY     = 30;
  localparam int HOLD_CYCLES = 200;
  localparam logic [2:0] CFG_UNUSED = 3'd7;

  logic         clk;
  logic         rst_n;
  logic [143:0] in_tdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [47:0]  out_tdata;
  logic [4:0]   out_tuser;
  logic         out_tlast;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic         cfg_wr_en;
  logic [2:0]   cfg_addr;
  logic [15:0]  cfg_wdata;

  split_scoreboard sb;
  bit  hold_req;   // ask for one long receiver hold-off
  bit  hold_on;    // receiver forced to stall
  int  rx_gap = 0; // cycles left in a random receiver gap
  bit  stall_en;

  triangle_plane_split_unit u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tdata(in_tdata), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser), .out_tlast(out_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #4 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("tb_triangle_plane_split_unit: FAIL");
    $finish;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(5, 25);
  endfunction

  // Count one long receiver hold-off once it is requested
  initial begin
    wait (hold_req);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // Accept results; stall at random and during the forced hold-off
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_vertex(out_tdata, out_tuser, out_tlast);
    if (!rst_n || hold_on) begin
      out_tready <= 0;
    end else if (rx_gap > 0) begin
      rx_gap <= rx_gap - 1;
      out_tready <= 0;
    end else if (stall_en && $urandom_range(0, 3) == 0) begin
      rx_gap <= gap_len();
      out_tready <= 0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    cfg_wr_en <= 1; cfg_addr <= idx; cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(int'(idx), val);
  endtask

  task automatic write_plane(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic [15:0] px, logic [15:0] py, logic [15:0] pz);
    write_reg(CFG_NORMAL_X, nx);
    write_reg(CFG_NORMAL_Y, ny);
    write_reg(CFG_NORMAL_Z, nz);
    write_reg(CFG_POINT_X, px);
    write_reg(CFG_POINT_Y, py);
    write_reg(CFG_POINT_Z, pz);
    cfg_wr_en <= 0;
  endtask

  // Offer one triangle and hold it until accepted
  task automatic send_triangle(logic [143:0] tri_data, bit gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_tvalid <= 0;
      repeat (g) @(posedge clk);
    end
    in_tdata <= tri_data;
    in_tvalid <= 1;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_triangle(tri_data);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_coord();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'h8000;
    if (r == 1) return 16'h7fff;
    if (r < 5) return 16'($signed($urandom_range(0, 4096)) - 2048);
    return 16'($urandom);
  endfunction

  function automatic logic [143:0] rand_triangle();
    logic [143:0] t;
    for (int i = 0; i < 9; i++) t[i*16 +: 16] = rand_coord();
    return t;
  endfunction

  function automatic logic [143:0] pack_tri(int ax, int ay, int az, int bx, int by,
                                            int bz, int cx, int cy, int cz);
    return {16'(cz), 16'(cy), 16'(cx), 16'(bz), 16'(by), 16'(bx),
            16'(az), 16'(ay), 16'(ax)};
  endfunction

  initial begin
    logic [15:0] p[6];
    sb = new();
    rst_n = 0; in_tvalid = 0; in_tdata = '0;
    cfg_wr_en = 0; cfg_addr = '0; cfg_wdata = '0;
    hold_req = 0; stall_en = 0;
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed: reset plane z = 0
    send_triangle(pack_tri(0, 0, 256, 256, 0, -256, 0, 256, 0), 0);
    send_triangle(pack_tri(0, 0, 0, 100, 0, 0, 0, 100, 0), 0);
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                           0, 0, 32767), 0);
    send_triangle(pack_tri(1, 2, 3, 4, 5, 6, 7, 8, 9), 0);
    send_triangle(pack_tri(0, 0, -1, 0, 0, 1, 0, 0, -5), 0);
    send_triangle(pack_tri(0, 0, 0, 0, 0, 300, 0, 0, -300), 0);
    send_triangle({144{1'b1}}, 0);
    send_triangle(pack_tri(32767, 0, -32768, -32768, 32767, 32767, 5, 5, 0), 0);
    drain();

    // Zero normal: all vertices on the plane
    write_plane(16'h0, 16'h0, 16'h0, 16'h7fff, 16'h8000, 16'h1234);
    send_triangle(pack_tri(1, -2, 3, 4, 5, -6, 7, 8, 9), 0);
    send_triangle(rand_triangle(), 0);
    drain();

    // Extreme normal and point
    write_plane(16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
    for (int i = 0; i < 6; i++) send_triangle(rand_triangle(), 0);
    send_triangle(pack_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                           32767, -32768, 0), 0);
    drain();

    // Random phases with fresh planes
    stall_en = 1;
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) write_plane(16'h0100, 16'h0100, 16'h0100, 16'h0, 16'h0, 16'h0);
      else begin
        for (int i = 0; i < 6; i++) p[i] = rand_coord();
        write_plane(p[0], p[1], p[2], p[3], p[4], p[5]);
      end
      for (int i = 0; i < 32; i++) begin
        // Long receiver hold-off while the sender keeps offering
        if (ph == 2 && i == 4) hold_req = 1;
        if (ph == 3 && i == 16) begin
          in_tvalid <= 0;
          @(posedge clk);
          while (sb.pending.size() != 0) @(posedge clk);
        end
        send_triangle(rand_triangle(), ph != 2);
      end
      drain();
    end

    // Finally drive the ignored register index
    cfg_wr_en <= 1; cfg_addr <= CFG_UNUSED; cfg_wdata <= 16'hffff;
    @(posedge clk);
    cfg_wr_en <= 0;
    send_triangle(rand_triangle(), 0);
    drain();

    if (sb.n_errors == 0 && sb.pending.size() == 0)
      $display("tb_triangle_plane_split_unit: PASS");
    else
      $display("tb_triangle_plane_split_unit: FAIL");
    $finish;
  end
endmodule
